FILE: rtl/ssfd_pkg.sv
// Package for the seven-segment frame decoder: frame layout constants,
// command and register codes, and the segment decode and digit weight tables.
// No dependencies.
`default_nettype none

package ssfd_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 24;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned UNIT_BYTES  = 5;

  // Field widths
  localparam int unsigned UNIT_W = 17;
  localparam int unsigned WIDE_W = 27;
  localparam int unsigned TICK_W = 17;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned WGT_W  = 24;
  localparam int unsigned DIG_W  = 4;

  // Byte position limits
  localparam logic [POS_W-1:0] POS_FRAME = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_UNIT  = POS_W'(UNIT_BYTES);

  // Byte groups within a frame (position bits [4:3])
  localparam logic [1:0] GRP_UNIT   = 2'd0;
  localparam logic [1:0] GRP_VOLUME = 2'd1;

  // Tick counter saturation value
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] CHANGE_GAP_RST = 16'd100;
  localparam logic [CFG_W-1:0] REFRESH_RST    = 16'd1000;

  // Input commands
  typedef enum logic {
    CMD_SEGMENT = 1'b0,
    CMD_TICK    = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic {
    REG_CHANGE_GAP = 1'b0,
    REG_REFRESH    = 1'b1
  } cfg_reg_t;

  // Map a segment code (point bit ignored) to its digit; unknown codes give 0
  function automatic logic [DIG_W-1:0] seg_digit(input logic [6:0] code);
    logic [DIG_W-1:0] d;
    unique case (code)
      7'h3F:   d = 4'd0;
      7'h06:   d = 4'd1;
      7'h5B:   d = 4'd2;
      7'h4F:   d = 4'd3;
      7'h66:   d = 4'd4;
      7'h6D:   d = 4'd5;
      7'h7D:   d = 4'd6;
      7'h47:   d = 4'd7;
      7'h07:   d = 4'd7;
      7'h7F:   d = 4'd8;
      7'h6F:   d = 4'd9;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  // Decimal weight of a digit by its place within a group of eight
  function automatic logic [WGT_W-1:0] digit_weight(input logic [2:0] place);
    logic [WGT_W-1:0] w;
    unique case (place)
      3'd0:    w = 24'd1;
      3'd1:    w = 24'd10;
      3'd2:    w = 24'd100;
      3'd3:    w = 24'd1000;
      3'd4:    w = 24'd10000;
      3'd5:    w = 24'd100000;
      3'd6:    w = 24'd1000000;
      default: w = 24'd10000000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/seven_seg_frame_decoder_core.sv
// Top level of the seven-segment frame decoder for one display channel.
// Depends on ssfd_pkg for constants, command codes and decode tables.
`default_nettype none

// Usage
// - in_* channel: one item per handshake. command=0 carries one segment byte
//   of a 24-byte frame (frame_end marks the last byte, frame_error on that
//   byte drops the frame); command=1 is one time tick.
// - out_* channel: a result carries unit price, volume and total; periodic_resend
//   is 0 for a newly sent frame and 1 for a resend of the held values.
// - cfg_* channel: index 0 = change gap in ticks, index 1 = refresh interval
//   in ticks. cfg_ready is always high; write only while the block is idle.
// Throughput and timing
// - One item per cycle while in_ready is high. Each item is decoded, weighted and
//   accumulated in the cycle it is accepted; its result, if any, sits in the
//   output register from the next cycle. The weight multiply, the add and the
//   frame compare between the input ports and the state registers set the cycle.
// Reset and stall
// - Synchronous reset clears the frame, the held values, the tick counter and
//   the output valid flag, and loads the configuration reset values.
// - While a result waits and out_ready is low, in_ready drops; a result taken
//   in the same cycle frees the output register for the next item.

module seven_seg_frame_decoder_core
  import ssfd_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  // Input channel
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   in_command,
  input  wire [7:0]             in_seg_byte,
  input  wire                   in_frame_end,
  input  wire                   in_frame_error,
  // Result channel
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [UNIT_W-1:0]     out_unit_cost,
  output logic [WIDE_W-1:0]     out_volume_count,
  output logic [WIDE_W-1:0]     out_sale_amount,
  output logic                  out_periodic_resend,
  // Configuration channel
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_index,
  input  wire [CFG_W-1:0]       cfg_data
);

  // Configuration registers
  logic [CFG_W-1:0]  change_gap_r;
  logic [CFG_W-1:0]  refresh_r;

  // Frame and held state
  logic [POS_W-1:0]  byte_pos_r,    byte_pos_nxt;
  logic [UNIT_W-1:0] unit_acc_r,    unit_acc_nxt;
  logic [WIDE_W-1:0] volume_acc_r,  volume_acc_nxt;
  logic [WIDE_W-1:0] total_acc_r,   total_acc_nxt;
  logic [UNIT_W-1:0] sent_unit_r,   sent_unit_nxt;
  logic [WIDE_W-1:0] sent_volume_r, sent_volume_nxt;
  logic [WIDE_W-1:0] sent_total_r,  sent_total_nxt;
  logic [TICK_W-1:0] ticks_r,       ticks_nxt;

  // Output register
  logic              out_valid_r,   out_valid_nxt;
  logic [UNIT_W-1:0] out_unit_r;
  logic [WIDE_W-1:0] out_volume_r;
  logic [WIDE_W-1:0] out_total_r;
  logic              out_resend_r;

  // Datapath signals
  logic              in_fire;
  logic              cfg_fire;
  logic [DIG_W-1:0]  digit;
  logic [WGT_W-1:0]  weight;
  logic [WIDE_W-1:0] term;
  logic [1:0]        group;
  logic [UNIT_W-1:0] unit_sum;
  logic [WIDE_W-1:0] volume_sum;
  logic [WIDE_W-1:0] total_sum;
  logic [TICK_W-1:0] ticks_inc;
  logic              differs;
  logic              emit;
  logic              emit_resend;

  // Handshakes: the output register parts the two sides
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // Decode and weight the current byte
  assign digit  = seg_digit(in_seg_byte[6:0]);
  assign weight = digit_weight(byte_pos_r[2:0]);
  assign term   = WIDE_W'(digit) * WIDE_W'(weight);
  assign group  = byte_pos_r[4:3];

  // Tick counter increment, saturating
  assign ticks_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;

  // Frame and tick processing
  always_comb begin
    byte_pos_nxt    = byte_pos_r;
    unit_acc_nxt    = unit_acc_r;
    volume_acc_nxt  = volume_acc_r;
    total_acc_nxt   = total_acc_r;
    sent_unit_nxt   = sent_unit_r;
    sent_volume_nxt = sent_volume_r;
    sent_total_nxt  = sent_total_r;
    ticks_nxt       = ticks_r;
    unit_sum        = unit_acc_r;
    volume_sum      = volume_acc_r;
    total_sum       = total_acc_r;
    differs         = 1'b0;
    emit            = 1'b0;
    emit_resend     = 1'b0;

    if (in_fire) begin
      if (cmd_t'(in_command) == CMD_TICK) begin
        // Advance the tick counter and resend held values when it runs out
        ticks_nxt = ticks_inc;
        if (ticks_inc > TICK_W'(refresh_r)) begin
          ticks_nxt   = '0;
          emit        = 1'b1;
          emit_resend = 1'b1;
        end
      end else begin
        // Accumulate the digit into its group
        if (byte_pos_r < POS_FRAME) begin
          priority if (group == GRP_UNIT) begin
            if (byte_pos_r < POS_UNIT) begin
              unit_sum = unit_acc_r + term[UNIT_W-1:0];
            end
          end else if (group == GRP_VOLUME) begin
            volume_sum = volume_acc_r + term;
          end else begin
            total_sum = total_acc_r + term;
          end
        end
        unit_acc_nxt   = unit_sum;
        volume_acc_nxt = volume_sum;
        total_acc_nxt  = total_sum;
        if (byte_pos_r <= POS_FRAME) begin
          byte_pos_nxt = byte_pos_r + 1'b1;
        end

        // Close the frame: send a good frame that changed or aged, then clear
        if (in_frame_end) begin
          differs = (unit_sum != sent_unit_r) || (volume_sum != sent_volume_r) ||
                    (total_sum != sent_total_r);
          if (!in_frame_error && (byte_pos_nxt == POS_FRAME) &&
              (differs || (ticks_r > TICK_W'(change_gap_r)))) begin
            sent_unit_nxt   = unit_sum;
            sent_volume_nxt = volume_sum;
            sent_total_nxt  = total_sum;
            ticks_nxt       = '0;
            emit            = 1'b1;
          end
          byte_pos_nxt   = '0;
          unit_acc_nxt   = '0;
          volume_acc_nxt = '0;
          total_acc_nxt  = '0;
        end
      end
    end
  end

  // Load the output register on a result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= '0;
      unit_acc_r    <= '0;
      volume_acc_r  <= '0;
      total_acc_r   <= '0;
      sent_unit_r   <= '0;
      sent_volume_r <= '0;
      sent_total_r  <= '0;
      ticks_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      byte_pos_r    <= byte_pos_nxt;
      unit_acc_r    <= unit_acc_nxt;
      volume_acc_r  <= volume_acc_nxt;
      total_acc_r   <= total_acc_nxt;
      sent_unit_r   <= sent_unit_nxt;
      sent_volume_r <= sent_volume_nxt;
      sent_total_r  <= sent_total_nxt;
      ticks_r       <= ticks_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_gap_r <= CHANGE_GAP_RST;
      refresh_r    <= REFRESH_RST;
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CHANGE_GAP: change_gap_r <= cfg_data;
        REG_REFRESH:    refresh_r    <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Output payload, loaded with the values being sent or resent
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_unit_r   <= sent_unit_nxt;
      out_volume_r <= sent_volume_nxt;
      out_total_r  <= sent_total_nxt;
      out_resend_r <= emit_resend;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_unit_cost       = out_unit_r;
  assign out_volume_count    = out_volume_r;
  assign out_sale_amount     = out_total_r;
  assign out_periodic_resend = out_resend_r;

  // A pending result always carries the held values
  a_out_matches_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_unit_r == sent_unit_r) && (out_volume_r == sent_volume_r) &&
                    (out_total_r == sent_total_r))
    else $error("pending result differs from held values");

  // Every result restarts the tick counter
  a_emit_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && emit) |=> (ticks_r == '0))
    else $error("tick counter not cleared after a result");

  // A frame end always rewinds the frame
  a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (cmd_t'(in_command) == CMD_SEGMENT) && in_frame_end)
      |=> (byte_pos_r == '0) && (unit_acc_r == '0) && (volume_acc_r == '0) &&
          (total_acc_r == '0))
    else $error("frame state not cleared after frame end");

  // Byte position saturates one past a full frame
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= POS_FRAME + 1'b1)
    else $error("byte position beyond saturation");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for seven_seg_frame_decoder_core: random valid/ready traffic
// with an item-level model of the frame decoder. Depends on ssfd_pkg and the core RTL.
`default_nettype none

module tb;
  import ssfd_pkg::*;

  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_CYCLES  = 4;
  localparam int HOLD_CYCLES  = 500;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [POS_W-1:0]  FRAME_LEN = POS_W'(FRAME_BYTES);
  localparam logic [POS_W-1:0]  UNIT_LEN  = POS_W'(UNIT_BYTES);
  localparam logic [TICK_W-1:0] TICK_TOP  = '1;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] seg_byte;
    logic       frame_end;
    logic       frame_error;
  } seg_item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] unit_cost;
    logic [WIDE_W-1:0] volume_count;
    logic [WIDE_W-1:0] sale_amount;
    logic              periodic_resend;
  } readout_t;

  // DUT connections, all inputs known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  wire               in_ready;
  cmd_t              in_command = CMD_SEGMENT;
  logic [7:0]        in_seg_byte = '0;
  logic              in_frame_end = 1'b0;
  logic              in_frame_error = 1'b0;
  wire               out_valid;
  logic              out_ready = 1'b0;
  wire [UNIT_W-1:0]  out_unit_cost;
  wire [WIDE_W-1:0]  out_volume_count;
  wire [WIDE_W-1:0]  out_sale_amount;
  wire               out_periodic_resend;
  logic              cfg_valid = 1'b0;
  wire               cfg_ready;
  cfg_reg_t          cfg_index = REG_CHANGE_GAP;
  logic [CFG_W-1:0]  cfg_data = '0;

  seven_seg_frame_decoder_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_seg_byte         (in_seg_byte),
    .in_frame_end        (in_frame_end),
    .in_frame_error      (in_frame_error),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_unit_cost       (out_unit_cost),
    .out_volume_count    (out_volume_count),
    .out_sale_amount     (out_sale_amount),
    .out_periodic_resend (out_periodic_resend),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Decoder model state
  logic [CFG_W-1:0]  gap_reg;
  logic [CFG_W-1:0]  refresh_reg;
  logic [POS_W-1:0]  byte_pos;
  logic [UNIT_W-1:0] acc_unit;
  logic [WIDE_W-1:0] acc_volume;
  logic [WIDE_W-1:0] acc_total;
  logic [UNIT_W-1:0] held_unit;
  logic [WIDE_W-1:0] held_volume;
  logic [WIDE_W-1:0] held_total;
  logic [TICK_W-1:0] tick_cnt;

  // Stimulus and scoreboard storage
  seg_item_t  item_q[$];
  readout_t   readout_q[$];
  logic [7:0] last_frame [FRAME_BYTES];
  int         items_queued = 0;
  int         items_taken = 0;
  int         fail_cnt = 0;
  int         cycle_cnt = 0;

  // Driver and receiver working variables
  seg_item_t  drv_item;
  readout_t   drv_readout;
  logic       drv_next;
  int         gap_left = 0;
  int         burst_left = 0;
  int         rx_mode = 0;
  int         rx_left = 0;
  int         hold_cnt = 0;
  logic       hold_go = 1'b0;
  logic       hold_done = 1'b0;
  logic       rx_rdy;
  readout_t   mon_got;
  readout_t   mon_want;

  always #HALF_PERIOD clk = ~clk;

  // Segment code to digit; point bit is not part of the code
  function automatic int unsigned seg_to_digit(input logic [6:0] code);
    case (code)
      7'h3F: return 0;
      7'h06: return 1;
      7'h5B: return 2;
      7'h4F: return 3;
      7'h66: return 4;
      7'h6D: return 5;
      7'h7D: return 6;
      7'h47, 7'h07: return 7;
      7'h7F: return 8;
      7'h6F: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned place_weight(input logic [2:0] place);
    int unsigned w;
    w = 1;
    repeat (place) w = w * 10;
    return w;
  endfunction

  task automatic reset_model();
    gap_reg     = CHANGE_GAP_RST;
    refresh_reg = REFRESH_RST;
    byte_pos    = '0;
    acc_unit    = '0;
    acc_volume  = '0;
    acc_total   = '0;
    held_unit   = '0;
    held_volume = '0;
    held_total  = '0;
    tick_cnt    = '0;
  endtask

  // Advance the decoder by one item; return 1 when it emits a readout
  function automatic bit decode_item(input seg_item_t it, output readout_t r);
    int unsigned addend;
    bit          sent;
    r = '0;
    sent = 1'b0;
    if (it.command == CMD_TICK) begin
      if (tick_cnt != TICK_TOP) tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt > {1'b0, refresh_reg}) begin
        tick_cnt = '0;
        r.unit_cost       = held_unit;
        r.volume_count    = held_volume;
        r.sale_amount     = held_total;
        r.periodic_resend = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    // accumulate the digit into its group, least significant first
    if (byte_pos < FRAME_LEN) begin
      addend = seg_to_digit(it.seg_byte[6:0]) * place_weight(byte_pos[2:0]);
      case (byte_pos[4:3])
        2'd0: begin
          if (byte_pos < UNIT_LEN) acc_unit = acc_unit + addend[UNIT_W-1:0];
        end
        2'd1: acc_volume = acc_volume + addend[WIDE_W-1:0];
        default: acc_total = acc_total + addend[WIDE_W-1:0];
      endcase
    end
    if (byte_pos <= FRAME_LEN) byte_pos = byte_pos + 1'b1;
    if (!it.frame_end) return 1'b0;
    // judge the frame, then clear it whatever the outcome
    if (!it.frame_error && byte_pos == FRAME_LEN) begin
      if (acc_unit != held_unit || acc_volume != held_volume || acc_total != held_total ||
          tick_cnt > {1'b0, gap_reg}) begin
        held_unit   = acc_unit;
        held_volume = acc_volume;
        held_total  = acc_total;
        tick_cnt    = '0;
        r.unit_cost       = acc_unit;
        r.volume_count    = acc_volume;
        r.sale_amount     = acc_total;
        r.periodic_resend = 1'b0;
        sent = 1'b1;
      end
    end
    byte_pos   = '0;
    acc_unit   = '0;
    acc_volume = '0;
    acc_total  = '0;
    return sent;
  endfunction

  function automatic logic [6:0] digit_code(input int d);
    case (d)
      0: return 7'h3F;
      1: return 7'h06;
      2: return 7'h5B;
      3: return 7'h4F;
      4: return 7'h66;
      5: return 7'h6D;
      6: return 7'h7D;
      7: return 7'h47;
      8: return 7'h7F;
      9: return 7'h6F;
      default: return 7'h07;
    endcase
  endfunction

  // Mostly known digit codes with a random point, sometimes any byte
  function automatic logic [7:0] rand_code();
    if ($urandom_range(0, 7) == 0) return 8'($urandom);
    return {1'($urandom_range(0, 1)), digit_code(int'($urandom_range(0, 10)))};
  endfunction

  // Same digit, possibly a different encoding of it
  function automatic logic [7:0] alias_code(input logic [7:0] b);
    logic [6:0] c;
    c = b[6:0];
    if (c == 7'h47 || c == 7'h07) c = ($urandom_range(0, 1) == 0) ? 7'h47 : 7'h07;
    return {1'($urandom_range(0, 1)), c};
  endfunction

  task automatic push_item(input cmd_t c, input logic [7:0] b, input logic fe, input logic fr);
    seg_item_t it;
    it.command     = c;
    it.seg_byte    = b;
    it.frame_end   = fe;
    it.frame_error = fr;
    item_q.push_back(it);
    items_queued++;
  endtask

  // Tick with random content in the fields it ignores
  task automatic push_tick();
    push_item(CMD_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Push one frame of len bytes; a repeat carries the digits of the last good frame
  task automatic push_frame(input int len, input bit err_end, input bit repeat_last);
    logic [7:0] b;
    bit         noisy;
    bit         good;
    noisy = ($urandom_range(0, 7) == 0);
    good  = (len == FRAME_BYTES) && !err_end && !repeat_last;
    for (int i = 0; i < len; i++) begin
      if (i >= FRAME_BYTES) b = 8'($urandom);
      else if (repeat_last && i >= UNIT_BYTES && i < 8) b = 8'($urandom);
      else if (repeat_last) b = alias_code(last_frame[i]);
      else b = rand_code();
      if (good) last_frame[i] = b;
      if ($urandom_range(0, 24) == 0) push_tick();
      push_item(CMD_SEGMENT, b, 1'(i == len - 1),
                (i == len - 1) ? err_end : (noisy & 1'($urandom_range(0, 1))));
    end
  endtask

  // Lone ending byte, a tick with all spare fields set, then a full frame that
  // walks every digit code with a tick inside and an error flag on an inner byte
  task automatic push_directed();
    logic [7:0] b;
    push_item(CMD_SEGMENT, 8'hFF, 1'b1, 1'b0);
    push_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
    for (int p = 0; p < FRAME_BYTES; p++) begin
      case (p)
        14: b = 8'h00;
        21: b = 8'h80;
        default: b = {1'(p % 2), digit_code(p % 11)};
      endcase
      if (p == 12) push_tick();
      push_item(CMD_SEGMENT, b, 1'(p == FRAME_BYTES - 1), 1'(p == 7));
      last_frame[p] = b;
    end
  endtask

  // Mostly well-formed frames, with repeats, broken frames and tick runs mixed in
  task automatic gen_phase(input int n, input int tick_run_max);
    int start;
    int pick;
    start = items_queued;
    while (items_queued - start < n) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 52) push_frame(FRAME_BYTES, 1'b0, 1'b0);
      else if (pick < 70) push_frame(FRAME_BYTES, 1'b0, 1'b1);
      else if (pick < 77) push_frame(int'($urandom_range(1, FRAME_BYTES - 1)), 1'b0, 1'b0);
      else if (pick < 82)
        push_frame(int'($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6)),
                   1'($urandom_range(0, 1)), 1'b0);
      else if (pick < 89) push_frame(FRAME_BYTES, 1'b1, 1'($urandom_range(0, 1)));
      else repeat ($urandom_range(1, tick_run_max)) push_tick();
    end
  endtask

  // Wait until every item is taken and every readout checked, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk); while (items_taken != items_queued || readout_q.size() != 0);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CHANGE_GAP) gap_reg = val;
    else refresh_reg = val;
  endtask

  // Driver: predict on acceptance, then offer the next item in bursts with gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (decode_item(drv_item, drv_readout)) readout_q.push_back(drv_readout);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        drv_next = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (item_q.size() != 0) begin
          drv_item = item_q.pop_front();
          in_command     <= drv_item.command;
          in_seg_byte    <= drv_item.seg_byte;
          in_frame_end   <= drv_item.frame_end;
          in_frame_error <= drv_item.frame_error;
          drv_next = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 5) == 0) ? int'($urandom_range(50, 150))
                                                     : int'($urandom_range(1, 20));
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
          end else begin
            burst_left--;
          end
        end
        in_valid <= drv_next;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = int'($urandom_range(0, 2));
        rx_left = int'($urandom_range(20, 120));
      end else begin
        rx_left--;
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        rx_rdy = 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_cnt  = HOLD_CYCLES - 1;
        rx_rdy    = 1'b0;
      end else begin
        case (rx_mode)
          0: rx_rdy = 1'b1;
          1: rx_rdy = 1'($urandom_range(0, 1));
          default: rx_rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      out_ready <= rx_rdy;
    end
  end

  // Monitor: compare each accepted readout with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      mon_got.unit_cost       = out_unit_cost;
      mon_got.volume_count    = out_volume_count;
      mon_got.sale_amount     = out_sale_amount;
      mon_got.periodic_resend = out_periodic_resend;
      if (readout_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("unexpected readout: unit=%0d vol=%0d total=%0d resend=%0b",
                   mon_got.unit_cost, mon_got.volume_count, mon_got.sale_amount,
                   mon_got.periodic_resend);
      end else begin
        mon_want = readout_q.pop_front();
        if (mon_got !== mon_want) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("readout mismatch: expected unit=%0d vol=%0d total=%0d resend=%0b, %s",
                     mon_want.unit_cost, mon_want.volume_count, mon_want.sale_amount,
                     mon_want.periodic_resend,
                     $sformatf("got unit=%0d vol=%0d total=%0d resend=%0b",
                               mon_got.unit_cost, mon_got.volume_count,
                               mon_got.sale_amount, mon_got.periodic_resend));
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  // Sequence: reset, directed items, then random phases under several settings
  initial begin
    reset_model();
    for (int i = 0; i < FRAME_BYTES; i++) last_frame[i] = 8'h3F;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    push_directed();
    gen_phase(200, 6);
    wait_idle();

    // lowest settings: every tick resends; hold the receiver off to back up the input
    write_cfg(REG_CHANGE_GAP, '0);
    write_cfg(REG_REFRESH, '0);
    @(negedge clk);
    hold_go = 1'b1;
    gen_phase(250, 6);
    wait_idle();

    // highest settings: unchanged frames are never resent
    write_cfg(REG_CHANGE_GAP, '1);
    write_cfg(REG_REFRESH, '1);
    gen_phase(150, 6);
    wait_idle();

    // small random settings so the gap and the refresh both fire
    write_cfg(REG_CHANGE_GAP, CFG_W'($urandom_range(0, 30)));
    write_cfg(REG_REFRESH, CFG_W'($urandom_range(0, 40)));
    gen_phase(300, 30);
    wait_idle();

    // wide random gap, moderate refresh
    write_cfg(REG_CHANGE_GAP, CFG_W'($urandom_range(0, 65535)));
    write_cfg(REG_REFRESH, CFG_W'($urandom_range(0, 200)));
    gen_phase(150, 40);
    wait_idle();

    if (fail_cnt == 0 && readout_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: seven_seg_frame_decoder_core.f
rtl/ssfd_pkg.sv
rtl/seven_seg_frame_decoder_core.sv
tb/sv/tb.sv
